/* hw/rtl/c3f_pkg.sv */
// Shared types and constants of the 3x3 clamped convolution filter.
// No dependencies; the interfaces, core and checker import it.
package c3f_pkg;

	localparam int PIX_W        = 8;
	localparam int COEF_W       = 16;
	localparam int COEF_FRAC    = 14;
	localparam int TAPS         = 3;
	localparam int KERNEL_W     = TAPS * COEF_W;
	localparam int DIM_W        = 12;
	localparam int ROW_W        = 11;
	localparam int HEIGHT_LIMIT = 2048;
	localparam int DIM_MIN      = 3;
	localparam int WIDTH_RESET  = 1920;
	localparam int HEIGHT_RESET = 1080;
	localparam int PIX_MAX      = 255;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = KERNEL_W;

	// product of unsigned pixel and signed coefficient, then sums
	localparam int PROD_W   = PIX_W + 1 + COEF_W;
	localparam int ROWSUM_W = PROD_W + 2;
	localparam int SUM_W    = ROWSUM_W + 2;

	localparam logic [KERNEL_W-1:0] KERNEL_RESET = 48'h071B_071B_071B;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_KERNEL_TOP    = 3'd2,
		REG_KERNEL_MIDDLE = 3'd3,
		REG_KERNEL_BOTTOM = 3'd4
	} cfg_reg_t;

endpackage

/* hw/rtl/c3f_if.sv */
// Handshake channels of the filter: pixel input, pixel output, register writes.
// Depends on c3f_pkg for field widths.
interface c3f_in_if;
	import c3f_pkg::*;
	logic             valid;
	logic             ready;
	logic             command;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output command, output pixel_in, input ready);
	modport sink (input valid, input command, input pixel_in, output ready);
endinterface

interface c3f_out_if;
	import c3f_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             frame_last;

	modport source (output valid, output pixel_out, output frame_last, input ready);
	modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface c3f_cfg_if;
	import c3f_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/c3f_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first: a read of the address written in the same cycle returns old data.
module c3f_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* hw/rtl/conv3x3_clamped_filter_core.sv */
// 3x3 convolution of an 8-bit luma plane in raster order, clamped to 0..255.
// Depends on c3f_pkg, the c3f_*_if interfaces and c3f_ram (two line stores).
//
// Channels: pix_in takes one word per pixel (command = pixel) or a flush word;
// pix_out gives one filtered word per result; cfg writes width, height and the
// three kernel rows (index 0..4), and is always ready.
// Results: from pixel width+1 of a frame on, each pixel word yields the result
// of the pixel width+1 places behind it. After the last pixel of a frame,
// width+1 flush words drain the rest; the last one carries frame_last. A pixel
// word during the drain, or a flush with nothing owed, gives no result.
// Border rows and columns pass through; interior pixels are filtered.
// Throughput: one word per clock unless the pipeline is full and pix_out is held.
// Stages after the store read: window, products, row sums, clamp to pix_out.
// Stall: each stage has its own valid, so bubbles close up; pix_in.ready drops
// only when every stage is full and pix_out is held by the receiver.
// Reset clears positions, drain count, window, kernel and sizes to defaults;
// line stores are not cleared and need no clearing pass.
module conv3x3_clamped_filter_core #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic clk,
	input  logic arst_n,
	c3f_in_if.sink    pix_in,
	c3f_out_if.source pix_out,
	c3f_cfg_if.sink   cfg
);
	import c3f_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int DW = $clog2(MAX_WIDTH + 2);
	localparam int CW = (WW > DIM_W) ? WW : DIM_W;
	localparam int WIDTH_INIT = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

	// configuration
	logic [WW-1:0]       width_q;
	logic [DIM_W-1:0]    height_q;
	logic [KERNEL_W-1:0] kernel_q [TAPS];

	// position state
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [DW-1:0]    drain_q;

	logic [PIX_W-1:0] win_q [TAPS][TAPS];

	// handshake
	logic cfg_acc, size_wr, in_acc, do_pix, do_drain, issue;
	logic free1, free2, free3, free4, free_o;

	// stage 1: line store read in flight
	logic             v_s1, drain_s1, upsel_s1, emit_s1, border_s1, last_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] px_s1, fwd_data_s1;
	logic [AW-1:0]    addr_s1;

	// stage 2..4
	logic             v_s2, border_s2, last_s2;
	logic [PIX_W-1:0] pass_s2;
	logic             v_s3, border_s3, last_s3;
	logic [PIX_W-1:0] pass_s3;
	logic signed [PROD_W-1:0] prod_s3 [TAPS][TAPS];
	logic             v_s4, border_s4, last_s4;
	logic [PIX_W-1:0] pass_s4;
	logic signed [ROWSUM_W-1:0] rowsum_s4 [TAPS];

	logic             out_v_q, out_last_q;
	logic [PIX_W-1:0] out_pix_q;

	// RAM ports
	logic [AW-1:0]    up_raddr, lo_raddr, drain_addr;
	logic [PIX_W-1:0] up_rdata, lo_rdata, up_val;
	logic             up_we, move1;

	// pixel-item decode
	logic [WW-1:0]    col_inc, width_m1;
	logic [DIM_W-1:0] row_inc;
	logic [DW-1:0]    width_p1;
	logic             emit_now, border_now;
	logic [AW-1:0]    pc_now;
	logic [ROW_W-1:0] pr_now;

	// config clamping
	logic [CW-1:0]    cfg_w_ext;
	logic [WW-1:0]    cfg_w_new;
	logic [DIM_W-1:0] cfg_h_new;

	// final sum
	logic signed [SUM_W-1:0] total;
	logic [PIX_W-1:0]        filt_pix;
	logic [SUM_W-1:0]        total_shr;

	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign size_wr   = cfg_acc
		&& ((cfg.index == REG_IMAGE_WIDTH) || (cfg.index == REG_IMAGE_HEIGHT));

	assign free_o = !out_v_q || pix_out.ready;
	assign free4  = !v_s4 || free_o;
	assign free3  = !v_s3 || free4;
	assign free2  = !v_s2 || free3;
	assign free1  = !v_s1 || free2;
	assign move1  = v_s1 && free2;

	assign pix_in.ready = free1;
	assign in_acc   = pix_in.valid && pix_in.ready;
	assign do_drain = in_acc && (drain_q != '0) && (pix_in.command == CMD_FLUSH);
	assign do_pix   = in_acc && (drain_q == '0) && (pix_in.command == CMD_PIXEL);
	assign issue    = do_drain || do_pix;

	assign width_m1   = width_q - WW'(1);
	assign width_p1   = DW'(width_q) + DW'(1);
	assign drain_addr = AW'(DW'(width_q) - drain_q);

	assign up_raddr = do_drain ? width_m1[AW-1:0] : col_q;
	assign lo_raddr = do_drain ? drain_addr : col_q;
	assign up_we    = move1 && !drain_s1;
	assign up_val   = fwd_s1 ? fwd_data_s1 : up_rdata;

	c3f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
		.clk   (clk),
		.we    (up_we),
		.waddr (addr_s1),
		.wdata (lo_rdata),
		.re    (issue),
		.raddr (up_raddr),
		.rdata (up_rdata)
	);

	c3f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_lower (
		.clk   (clk),
		.we    (do_pix),
		.waddr (col_q),
		.wdata (pix_in.pixel_in),
		.re    (issue),
		.raddr (lo_raddr),
		.rdata (lo_rdata)
	);

	// position of the window center for this pixel
	always_comb begin
		col_inc  = WW'(col_q) + WW'(1);
		row_inc  = DIM_W'(row_q) + DIM_W'(1);
		emit_now = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
		if (col_q != '0) begin
			pr_now = row_q - ROW_W'(1);
			pc_now = col_q - AW'(1);
		end else begin
			pr_now = row_q - ROW_W'(2);
			pc_now = width_m1[AW-1:0];
		end
		border_now = (pr_now == '0) || (pr_now == ROW_W'(height_q - DIM_W'(1)))
			|| (pc_now == '0) || (pc_now == width_m1[AW-1:0]);
	end

	always_comb begin
		cfg_w_ext = CW'(cfg.data[DIM_W-1:0]);
		if (cfg_w_ext < CW'(DIM_MIN)) begin
			cfg_w_new = WW'(DIM_MIN);
		end else if (cfg_w_ext > CW'(MAX_WIDTH)) begin
			cfg_w_new = WW'(MAX_WIDTH);
		end else begin
			cfg_w_new = cfg_w_ext[WW-1:0];
		end
		if (cfg.data[DIM_W-1:0] < DIM_W'(DIM_MIN)) begin
			cfg_h_new = DIM_W'(DIM_MIN);
		end else if (cfg.data[DIM_W-1:0] > DIM_W'(HEIGHT_LIMIT)) begin
			cfg_h_new = DIM_W'(HEIGHT_LIMIT);
		end else begin
			cfg_h_new = cfg.data[DIM_W-1:0];
		end
	end

	// kernel rows; a write never holds up the pixel position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				kernel_q[i] <= KERNEL_RESET;
			end
		end else if (cfg_acc) begin
			unique case (cfg.index)
				REG_KERNEL_TOP:    kernel_q[0] <= cfg.data;
				REG_KERNEL_MIDDLE: kernel_q[1] <= cfg.data;
				REG_KERNEL_BOTTOM: kernel_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	// frame size and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(WIDTH_INIT);
			height_q <= DIM_W'(HEIGHT_RESET);
			col_q    <= '0;
			row_q    <= '0;
			drain_q  <= '0;
		end else if (size_wr) begin
			if (cfg.index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_w_new;
			end else begin
				height_q <= cfg_h_new;
			end
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (do_pix) begin
			if (col_inc == width_q) begin
				col_q <= '0;
				if (row_inc == height_q) begin
					row_q   <= '0;
					drain_q <= width_p1;
				end else begin
					row_q <= row_inc[ROW_W-1:0];
				end
			end else begin
				col_q <= col_inc[AW-1:0];
			end
		end else if (do_drain) begin
			drain_q <= drain_q - DW'(1);
		end
	end

	// stage 1 control; the upper store write of the leaving item is forwarded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (free1) begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			drain_s1    <= do_drain;
			upsel_s1    <= (drain_q == width_p1);
			emit_s1     <= do_drain || emit_now;
			border_s1   <= do_drain || border_now;
			last_s1     <= do_drain && (drain_q == DW'(1));
			px_s1       <= pix_in.pixel_in;
			addr_s1     <= col_q;
			fwd_s1      <= up_we && (up_raddr == addr_s1);
			fwd_data_s1 <= lo_rdata;
		end
	end

	// window slides on every pixel leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				for (int j = 0; j < TAPS; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (up_we) begin
			for (int i = 0; i < TAPS; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= up_val;
			win_q[1][2] <= lo_rdata;
			win_q[2][2] <= px_s1;
		end
	end

	// stage 2..4 and output valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (free2) begin
				v_s2 <= move1 && emit_s1;
			end
			if (free3) begin
				v_s3 <= v_s2;
			end
			if (free4) begin
				v_s4 <= v_s3;
			end
			if (free_o) begin
				out_v_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free2) begin
			border_s2 <= border_s1;
			last_s2   <= last_s1;
			// center after the slide is the current middle-right tap
			pass_s2   <= drain_s1 ? (upsel_s1 ? up_val : lo_rdata) : win_q[1][2];
		end
		if (free3) begin
			border_s3 <= border_s2;
			last_s3   <= last_s2;
			pass_s3   <= pass_s2;
			for (int i = 0; i < TAPS; i++) begin
				for (int j = 0; j < TAPS; j++) begin
					prod_s3[i][j] <= $signed({1'b0, win_q[i][j]})
						* $signed(kernel_q[i][COEF_W*j +: COEF_W]);
				end
			end
		end
		if (free4) begin
			border_s4 <= border_s3;
			last_s4   <= last_s3;
			pass_s4   <= pass_s3;
			for (int i = 0; i < TAPS; i++) begin
				rowsum_s4[i] <= ROWSUM_W'(prod_s3[i][0]) + ROWSUM_W'(prod_s3[i][1])
					+ ROWSUM_W'(prod_s3[i][2]);
			end
		end
		if (free_o) begin
			out_pix_q  <= border_s4 ? pass_s4 : filt_pix;
			out_last_q <= last_s4;
		end
	end

	// negative sums clamp to zero, then drop the fraction and saturate
	always_comb begin
		total = SUM_W'(rowsum_s4[0]) + SUM_W'(rowsum_s4[1]) + SUM_W'(rowsum_s4[2]);
		total_shr = SUM_W'(total >>> COEF_FRAC);
		if (total < 0) begin
			filt_pix = '0;
		end else if (total_shr > SUM_W'(PIX_MAX)) begin
			filt_pix = PIX_W'(PIX_MAX);
		end else begin
			filt_pix = total_shr[PIX_W-1:0];
		end
	end

	assign pix_out.valid      = out_v_q;
	assign pix_out.pixel_out  = out_pix_q;
	assign pix_out.frame_last = out_last_q;

endmodule

/* hw/rtl/c3f_checker.sv */
// Port-level checks of the filter core, bound into conv3x3_clamped_filter_core.
// Depends on c3f_pkg for widths and on the core's interface ports.
module c3f_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [c3f_pkg::PIX_W-1:0] pixel_out,
	input logic frame_last
);
	import c3f_pkg::*;

	// no result word can be shown while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(frame_last))
		else $error("output word changed while stalled");

	// input stalls only when the whole pipeline is backed up by the receiver
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input not ready without output backpressure");

	// the word after the last one of a frame cannot close a frame again
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && frame_last |=> !(out_valid && frame_last))
		else $error("two frame-closing words in a row");

endmodule

bind conv3x3_clamped_filter_core c3f_checker u_c3f_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (pix_in.ready),
	.out_valid  (pix_out.valid),
	.out_ready  (pix_out.ready),
	.pixel_out  (pix_out.pixel_out),
	.frame_last (pix_out.frame_last)
);

/* bench/conv3x3_clamped_filter_core_test.sv */
// Self-checking bench for conv3x3_clamped_filter_core: directed and random frames,
// predicted results compared word by word. Needs c3f_pkg, the c3f_*_if interfaces
// and the core with its line store RAM.
module conv3x3_clamped_filter_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import c3f_pkg::*;

	localparam int          MAX_W         = 2048;
	localparam int unsigned RANDOM_WORDS  = 1750;
	localparam int unsigned QUIET_LIMIT   = 4000;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_KERNEL_BOTTOM + 1);
	localparam int unsigned SPARE_COUNT = (1 << CFG_IDX_W) - REG_SPARE_FIRST;

	typedef struct packed {
		cmd_t             command;
		logic [PIX_W-1:0] pixel;
		logic             hold;     // wait for all results before sending
	} px_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} pix_result_t;

	logic clk = 1'b0;
	logic arst_n;

	c3f_in_if  pix_in_ch ();
	c3f_out_if pix_out_ch ();
	c3f_cfg_if cfg_ch ();

	conv3x3_clamped_filter_core #(.MAX_WIDTH(MAX_W)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_ch),
		.pix_out (pix_out_ch),
		.cfg     (cfg_ch)
	);

	always #5 clk = ~clk;

	// filter state as seen from outside
	logic [DIM_W-1:0]    width_reg;
	logic [DIM_W-1:0]    height_reg;
	logic [KERNEL_W-1:0] kernel_reg [TAPS];
	logic [PIX_W-1:0]    upper_row_px [MAX_W];
	logic [PIX_W-1:0]    lower_row_px [MAX_W];
	logic [PIX_W-1:0]    window_px [3][3];
	int unsigned         col_pos;
	int unsigned         row_pos;
	int unsigned         drain_left;

	px_word_t    pending_words [$];
	pix_result_t expected_px [$];

	int unsigned well_formed_words;
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned quiet_cycles;
	int unsigned send_gap, send_calm;
	int unsigned recv_stall, recv_calm, results_to_hold;

	function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned top);
		if (v < DIM_MIN)
			return DIM_MIN;
		if (v > top)
			return top;
		return v;
	endfunction

	function automatic void reset_filter_model();
		int i, j;
		width_reg = DIM_W'(WIDTH_RESET);
		height_reg = DIM_W'(HEIGHT_RESET);
		for (i = 0; i < TAPS; i++)
			kernel_reg[i] = KERNEL_RESET;
		for (i = 0; i < MAX_W; i++) begin
			upper_row_px[i] = '0;
			lower_row_px[i] = '0;
		end
		for (i = 0; i < 3; i++)
			for (j = 0; j < 3; j++)
				window_px[i][j] = '0;
		col_pos = 0;
		row_pos = 0;
		drain_left = 0;
	endfunction

	function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: begin
				if (idx == REG_IMAGE_WIDTH)
					width_reg = value[DIM_W-1:0];
				else
					height_reg = value[DIM_W-1:0];
				// size change aborts the frame and any drain
				col_pos = 0;
				row_pos = 0;
				drain_left = 0;
			end
			REG_KERNEL_TOP, REG_KERNEL_MIDDLE, REG_KERNEL_BOTTOM: begin
				kernel_reg[idx - REG_KERNEL_TOP] = value;
			end
			default: ;
		endcase
	endfunction

	// one accepted input word; queues the result it causes, if any
	function automatic void filter_step(cmd_t cmd, logic [PIX_W-1:0] px);
		int unsigned w, h, r, c, pr, pc, d, i, j;
		bit          emit;
		longint      acc;
		pix_result_t res;
		w = clamp_dim(width_reg, MAX_W);
		h = clamp_dim(height_reg, HEIGHT_LIMIT);
		if (drain_left > 0) begin
			if (cmd == CMD_PIXEL)
				return;
			d = (drain_left > w + 1) ? w + 1 : drain_left;
			res.pixel = (d == w + 1) ? upper_row_px[w-1] : lower_row_px[w-d];
			res.last = (d == 1);
			expected_px.push_back(res);
			drain_left = d - 1;
			return;
		end
		if (cmd == CMD_FLUSH)
			return;

		r = row_pos;
		c = col_pos;
		if (c >= w || r >= h) begin
			r = 0;
			c = 0;
		end
		for (i = 0; i < 3; i++) begin
			window_px[i][0] = window_px[i][1];
			window_px[i][1] = window_px[i][2];
		end
		window_px[0][2] = upper_row_px[c];
		window_px[1][2] = lower_row_px[c];
		window_px[2][2] = px;
		upper_row_px[c] = lower_row_px[c];
		lower_row_px[c] = px;

		emit = (r >= 2) || (r == 1 && c >= 1);
		if (c >= 1) begin
			pr = r - 1;
			pc = c - 1;
		end else begin
			pr = r - 2;
			pc = w - 1;
		end
		c++;
		if (c == w) begin
			c = 0;
			r++;
			if (r == h) begin
				r = 0;
				drain_left = w + 1;
			end
		end
		col_pos = c;
		row_pos = r;

		if (!emit)
			return;
		if (pr == 0 || pr == h - 1 || pc == 0 || pc == w - 1) begin
			res.pixel = window_px[1][1];
		end else begin
			acc = 0;
			for (i = 0; i < 3; i++)
				for (j = 0; j < 3; j++)
					acc += longint'(window_px[i][j]) *
						longint'($signed(kernel_reg[i][j*COEF_W +: COEF_W]));
			if (acc < 0)
				res.pixel = '0;
			else begin
				acc = acc >>> COEF_FRAC;
				res.pixel = (acc > PIX_MAX) ? PIX_W'(PIX_MAX) : acc[PIX_W-1:0];
			end
		end
		res.last = 1'b0;
		expected_px.push_back(res);
	endfunction

	// mostly back-to-back, some short gaps, a few long ones, now and then a calm run
	function automatic int unsigned next_gap(inout int unsigned calm);
		int unsigned roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 999);
		if (roll < 8) begin
			calm = $urandom_range(40, 250);
			return 0;
		end
		if (roll < 550)
			return 0;
		if (roll < 880)
			return $urandom_range(1, 3);
		if (roll < 980)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [47:0] random48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [DIM_W-1:0] draw_dim(int unsigned usual_top, int unsigned far_top);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return DIM_W'($urandom_range(0, DIM_MIN - 1));   // saturates up
		if (roll < 75)
			return DIM_W'($urandom_range(DIM_MIN, usual_top));
		return DIM_W'($urandom_range(usual_top + 1, far_top));
	endfunction

	function automatic logic [KERNEL_W-1:0] draw_kernel_row();
		logic [KERNEL_W-1:0] row;
		logic [COEF_W-1:0]   tap;
		int unsigned         style, j;
		style = $urandom_range(0, 5);
		for (j = 0; j < TAPS; j++) begin
			case (style)
				0: tap = COEF_W'($urandom);
				1, 2: tap = COEF_W'($urandom_range(0, 2000));
				3, 4: tap = COEF_W'($urandom_range(0, 12000)) - COEF_W'(6000);
				default: begin
					case ($urandom_range(0, 3))
						0: tap = 16'h7FFF;
						1: tap = 16'h8000;
						2: tap = 16'hFFFF;
						default: tap = 16'h0000;
					endcase
				end
			endcase
			row[j*COEF_W +: COEF_W] = tap;
		end
		return row;
	endfunction

	function automatic logic [PIX_W-1:0] draw_pixel(int unsigned style);
		case (style)
			0: return PIX_W'($urandom_range(0, PIX_MAX));
			1: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return PIX_W'(PIX_MAX);
					default: return PIX_W'($urandom_range(0, PIX_MAX));
				endcase
			end
			default: return PIX_W'($urandom_range(100, 160));
		endcase
	endfunction

	function automatic void push_word(cmd_t cmd, logic [PIX_W-1:0] px, bit hold_first,
			bit noise);
		px_word_t w;
		w.command = cmd;
		w.pixel = px;
		w.hold = hold_first;
		pending_words.push_back(w);
		if (!noise)
			well_formed_words++;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		apply_reg_write(idx, value);
		cfg_ch.valid <= 1'b0;
	endtask

	// all words sent, all results in, then let the pipeline empty
	task automatic settle();
		while (pending_words.size() != 0 || pix_in_ch.valid || expected_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_words
		px_word_t word;
		if (!arst_n) begin
			pix_in_ch.valid <= 1'b0;
			pix_in_ch.command <= CMD_PIXEL;
			pix_in_ch.pixel_in <= '0;
			send_gap = 0;
			send_calm = 0;
			reset_filter_model();
		end else begin
			if (pix_in_ch.valid && pix_in_ch.ready)
				filter_step(cmd_t'(pix_in_ch.command), pix_in_ch.pixel_in);
			if (!pix_in_ch.valid || pix_in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					pix_in_ch.valid <= 1'b0;
				end else if (pending_words.size() != 0 &&
						!(pending_words[0].hold && expected_px.size() != 0)) begin
					word = pending_words.pop_front();
					pix_in_ch.valid <= 1'b1;
					pix_in_ch.command <= word.command;
					pix_in_ch.pixel_in <= word.pixel;
					send_gap = next_gap(send_calm);
				end else begin
					pix_in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		pix_result_t want;
		if (!arst_n) begin
			pix_out_ch.ready <= 1'b0;
			recv_stall = 0;
			recv_calm = 0;
			results_to_hold = 250;
		end else begin
			if (pix_out_ch.valid && pix_out_ch.ready) begin
				if (expected_px.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: word with none expected: pixel_out=%0d frame_last=%0b",
							$time, pix_out_ch.pixel_out, pix_out_ch.frame_last);
				end else begin
					want = expected_px.pop_front();
					if (pix_out_ch.pixel_out !== want.pixel ||
							pix_out_ch.frame_last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result %0d: pixel_out exp %0d got %0d, %s",
								$time, results_seen, want.pixel, pix_out_ch.pixel_out,
								$sformatf("frame_last exp %0b got %0b",
									want.last, pix_out_ch.frame_last));
					end
				end
				results_seen++;
				results_to_hold--;
				// long back-pressure so the pipeline fills and stalls the input
				if (results_to_hold == 0) begin
					recv_stall = $urandom_range(200, 400);
					results_to_hold = 700;
				end
			end
			if (recv_stall > 0)
				recv_stall--;
			else
				recv_stall = next_gap(recv_calm);
			pix_out_ch.ready <= (recv_stall == 0);
		end
	end

	always @(posedge clk) begin
		if ((pix_in_ch.valid && pix_in_ch.ready) || (pix_out_ch.valid && pix_out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("conv3x3_clamped_filter_core_test NOT OK");
		$finish;
	end

	initial begin : run
		int unsigned w, h, n, f, k, nframes, px_total, split_at, flush_count, mode, style;
		bit          aborted, force_size;
		logic [47:0] junk;

		arst_n = 1'b0;
		quiet_cycles = 0;
		mismatches = 0;
		results_seen = 0;
		well_formed_words = 0;
		pix_in_ch.valid = 1'b0;
		pix_in_ch.command = CMD_PIXEL;
		pix_in_ch.pixel_in = '0;
		pix_out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_IMAGE_WIDTH;
		cfg_ch.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest frame, width and height written below range, strongest positive taps
		write_reg(REG_IMAGE_WIDTH, '0);
		write_reg(REG_IMAGE_HEIGHT, 48'd2);
		for (k = 0; k < TAPS; k++)
			write_reg(cfg_reg_t'(REG_KERNEL_TOP + k), 48'h7FFF_7FFF_7FFF);
		push_word(CMD_FLUSH, '0, 1'b0, 1'b1);            // nothing owed: ignored
		for (n = 0; n < 9; n++)
			push_word(CMD_PIXEL, (n % 2 == 0) ? 8'hFF : 8'h00, 1'b0, 1'b0);
		push_word(CMD_FLUSH, '0, 1'b0, 1'b0);
		push_word(CMD_FLUSH, '0, 1'b0, 1'b0);
		push_word(CMD_PIXEL, 8'hA5, 1'b0, 1'b1);         // dropped during drain
		push_word(CMD_FLUSH, '0, 1'b0, 1'b0);
		push_word(CMD_FLUSH, '0, 1'b0, 1'b0);
		settle();

		// most negative taps clamp to zero; drain cut short by the next size write
		for (k = 0; k < TAPS; k++)
			write_reg(cfg_reg_t'(REG_KERNEL_TOP + k), 48'h8000_8000_8000);
		write_reg(CFG_IDX_W'(REG_SPARE_FIRST + $urandom_range(0, SPARE_COUNT - 1)),
			random48());
		for (n = 0; n < 9; n++)
			push_word(CMD_PIXEL, draw_pixel(0), n == 0, 1'b0);
		push_word(CMD_FLUSH, '0, 1'b0, 1'b0);
		push_word(CMD_FLUSH, '0, 1'b0, 1'b0);
		settle();

		// widest line, sizes saturating down; a row and a bit, then aborted
		junk = random48();
		write_reg(REG_IMAGE_WIDTH, {junk[47:DIM_W], {DIM_W{1'b1}}});
		junk = random48();
		write_reg(REG_IMAGE_HEIGHT, {junk[47:DIM_W], {DIM_W{1'b1}}});
		for (n = 0; n < MAX_W + 40; n++)
			push_word(CMD_PIXEL, draw_pixel(0), 1'b0, 1'b1);
		settle();

		force_size = 1'b1;
		well_formed_words = 0;
		while (well_formed_words < RANDOM_WORDS) begin
			settle();
			if (force_size || $urandom_range(0, 3) == 0) begin
				junk = random48();
				write_reg(REG_IMAGE_WIDTH, {junk[47:DIM_W], draw_dim(8, 40)});
				junk = random48();
				write_reg(REG_IMAGE_HEIGHT, {junk[47:DIM_W], draw_dim(5, 8)});
				force_size = 1'b0;
			end
			for (k = 0; k < TAPS; k++)
				if ($urandom_range(0, 1))
					write_reg(cfg_reg_t'(REG_KERNEL_TOP + k), draw_kernel_row());
			if ($urandom_range(0, 15) == 0)
				write_reg(CFG_IDX_W'(REG_SPARE_FIRST + $urandom_range(0, SPARE_COUNT - 1)),
					random48());
			w = clamp_dim(width_reg, MAX_W);
			h = clamp_dim(height_reg, HEIGHT_LIMIT);
			nframes = $urandom_range(1, 3);
			aborted = 1'b0;
			for (f = 0; f < nframes && !aborted; f++) begin
				style = $urandom_range(0, 2);
				// mode 1: frame cut short, 2: drain cut short, 3: extra flushes
				mode = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
				px_total = (mode == 1) ? $urandom_range(1, w * h - 1) : w * h;
				split_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h - 1) : 0;
				if ($urandom_range(0, 9) == 0)
					push_word(CMD_FLUSH, '0, 1'b0, 1'b1);
				for (n = 0; n < px_total; n++) begin
					if (n == split_at) begin
						// kernel swap mid-frame, block idle
						settle();
						write_reg(cfg_reg_t'(REG_KERNEL_TOP + $urandom_range(0, TAPS - 1)),
							draw_kernel_row());
					end
					push_word(CMD_PIXEL, draw_pixel(style),
						n == 0 && $urandom_range(0, 4) == 0, 1'b0);
				end
				if (mode == 1) begin
					aborted = 1'b1;
				end else begin
					flush_count = (mode == 2) ? $urandom_range(0, w) : w + 1;
					for (n = 0; n < flush_count; n++) begin
						if ($urandom_range(0, 9) == 0)
							push_word(CMD_PIXEL, draw_pixel(0), 1'b0, 1'b1);
						push_word(CMD_FLUSH, '0, 1'b0, 1'b0);
					end
					if (mode == 3)
						for (n = $urandom_range(1, 3); n > 0; n--)
							push_word(CMD_FLUSH, '0, 1'b0, 1'b1);
					if (mode == 2)
						aborted = 1'b1;
				end
			end
			if (aborted)
				force_size = 1'b1;
		end

		settle();
		if (mismatches == 0)
			$display("conv3x3_clamped_filter_core_test OK");
		else
			$display("conv3x3_clamped_filter_core_test NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/c3f_pkg.sv
hw/rtl/c3f_if.sv
hw/rtl/c3f_ram.sv
hw/rtl/conv3x3_clamped_filter_core.sv
hw/rtl/c3f_checker.sv
bench/conv3x3_clamped_filter_core_test.sv
